### rtl/core/zncc_pkg.sv
// Shared constants for the ZNCC matching cost pipeline.
package zncc_pkg;

  localparam int unsigned SUM_BITS_DEF    = 17;
  localparam int unsigned SQ_BITS_DEF     = 25;
  localparam int unsigned N_BITS          = 9;
  localparam int unsigned COST_BITS       = 16;
  localparam int unsigned FRAC_BITS       = 15;
  localparam logic [N_BITS-1:0] N_RESET   = 9'd81;

endpackage

### rtl/core/zncc_moments.sv
// Centred moments and variance product: four register stages.
module zncc_moments #(
  parameter int unsigned SumBits = zncc_pkg::SUM_BITS_DEF,
  parameter int unsigned SqBits  = zncc_pkg::SQ_BITS_DEF,
  localparam int unsigned PA = SqBits + zncc_pkg::N_BITS,
  localparam int unsigned PB = 2 * SumBits,
  localparam int unsigned P  = (PA > PB) ? PA : PB
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [zncc_pkg::N_BITS-1:0]       n_i,
  input  logic [SumBits-1:0]                si_i,
  input  logic [SqBits-1:0]                 sii_i,
  input  logic [SumBits-1:0]                sj_i,
  input  logic [SqBits-1:0]                 sjj_i,
  input  logic [SqBits-1:0]                 sij_i,
  output logic                              vld_o,
  output logic signed [P:0]                 num_o,
  output logic [2*P-1:0]                    rad_o
);
  import zncc_pkg::*;

  localparam int unsigned H  = (P + 1) / 2;
  localparam int unsigned HH = P - H;

  logic [3:0] vld_q;

  // stage 1: raw products
  logic [PA-1:0] nsij_q, nsii_q, nsjj_q;
  logic [PB-1:0] sisj_q, sisi_q, sjsj_q;
  // stage 2: differences
  logic signed [P:0] num2_q, num3_q, num4_q;
  logic [P-1:0]      vi_q, vj_q;
  // stage 3: partial products
  logic [2*H-1:0]    pll_q;
  logic [H+HH-1:0]   plh_q, phl_q;
  logic [2*HH-1:0]   phh_q;
  logic [2*P-1:0]    rad_q;

  logic signed [P:0] num_d, vis_d, vjs_d;
  logic [P:0]        vim_d, vjm_d;

  always_comb begin
    num_d = signed'({1'b0, (P)'(nsij_q)}) - signed'({1'b0, (P)'(sisj_q)});
    vis_d = signed'({1'b0, (P)'(nsii_q)}) - signed'({1'b0, (P)'(sisi_q)});
    vjs_d = signed'({1'b0, (P)'(nsjj_q)}) - signed'({1'b0, (P)'(sjsj_q)});
    vim_d = vis_d[P] ? -vis_d : vis_d;
    vjm_d = vjs_d[P] ? -vjs_d : vjs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nsij_q <= PA'(n_i * sij_i);
      nsii_q <= PA'(n_i * sii_i);
      nsjj_q <= PA'(n_i * sjj_i);
      sisj_q <= PB'(si_i * sj_i);
      sisi_q <= PB'(si_i * si_i);
      sjsj_q <= PB'(sj_i * sj_i);
      num2_q <= num_d;
      vi_q   <= vim_d[P-1:0];
      vj_q   <= vjm_d[P-1:0];
      num3_q <= num2_q;
      pll_q  <= (2*H)'(vi_q[H-1:0] * vj_q[H-1:0]);
      plh_q  <= (H+HH)'(vi_q[H-1:0] * vj_q[P-1:H]);
      phl_q  <= (H+HH)'(vi_q[P-1:H] * vj_q[H-1:0]);
      phh_q  <= (2*HH)'(vi_q[P-1:H] * vj_q[P-1:H]);
      num4_q <= num3_q;
      rad_q  <= (2*P)'(pll_q)
              + ((2*P)'(plh_q) << H) + ((2*P)'(phl_q) << H)
              + ((2*P)'(phh_q) << (2*H));
    end
  end

  assign vld_o = vld_q[3];
  assign num_o = num4_q;
  assign rad_o = rad_q;

endmodule

### rtl/core/zncc_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module zncc_sqrt #(
  parameter int unsigned P = 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [P:0]   num_i,
  input  logic [2*P-1:0]      rad_i,
  output logic                vld_o,
  output logic signed [P:0]   num_o,
  output logic [P-1:0]        root_o
);
  import zncc_pkg::*;

  logic              vld_q  [P];
  logic [P+1:0]      rem_q  [P];
  logic [P-1:0]      root_q [P];
  logic [2*P-1:0]    rad_q  [P];
  logic signed [P:0] num_q  [P];

  for (genvar k = 0; k < P; k++) begin : g_step
    logic              vld_in;
    logic [P+1:0]      rem_in, rem_sh, trial;
    logic [P-1:0]      root_in;
    logic [2*P-1:0]    rad_in;
    logic signed [P:0] num_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign num_in  = num_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign num_in  = num_q[k-1];
    end

    assign rem_sh = {rem_in[P-1:0], rad_in[2*P-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[P-2:0], ge};
        rad_q[k]  <= rad_in << 2;
        num_q[k]  <= num_in;
      end
    end
  end

  assign vld_o  = vld_q[P-1];
  assign num_o  = num_q[P-1];
  assign root_o = root_q[P-1];

endmodule

### rtl/core/zncc_div.sv
// Pipelined restoring divide to Q1.15 with sign and saturation.
module zncc_div #(
  parameter int unsigned P = 34
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic signed [P:0]                  num_i,
  input  logic [P-1:0]                       root_i,
  output logic                               vld_o,
  output logic [zncc_pkg::COST_BITS-1:0]     cost_o,
  output logic                               zden_o
);
  import zncc_pkg::*;

  localparam int unsigned NS = FRAC_BITS + 1;

  logic                 vld_q  [NS];
  logic [P-1:0]         r_q    [NS];
  logic [P-1:0]         root_q [NS];
  logic [FRAC_BITS-1:0] q_q    [NS];
  logic                 sat_q  [NS];
  logic                 neg_q  [NS];
  logic                 zero_q [NS];

  logic                 out_vld_q;
  logic [COST_BITS-1:0] cost_q;
  logic                 zden_q;

  // setup: magnitude, saturation and zero-root flags
  logic [P:0] amag;
  assign amag = num_i[P] ? -num_i : num_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= amag[P-1:0];
      root_q[0] <= root_i;
      q_q[0]    <= '0;
      sat_q[0]  <= amag[P-1:0] >= root_i;
      neg_q[0]  <= num_i[P];
      zero_q[0] <= root_i == '0;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [P:0] r_sh;
    logic       ge;

    assign r_sh = {r_q[k-1], 1'b0};
    assign ge   = r_sh >= {1'b0, root_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? P'(r_sh - {1'b0, root_q[k-1]}) : r_sh[P-1:0];
        root_q[k] <= root_q[k-1];
        q_q[k]    <= {q_q[k-1][FRAC_BITS-2:0], ge};
        sat_q[k]  <= sat_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // final: sign, saturation, zero root
  logic [COST_BITS-1:0] mag_d, cost_d;
  always_comb begin
    mag_d = sat_q[NS-1] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, q_q[NS-1]};
    if (zero_q[NS-1]) begin
      cost_d = '0;
    end else if (neg_q[NS-1]) begin
      cost_d = -mag_d;
    end else if (sat_q[NS-1]) begin
      cost_d = {1'b0, {FRAC_BITS{1'b1}}};
    end else begin
      cost_d = mag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cost_q <= cost_d;
      zden_q <= zero_q[NS-1];
    end
  end

  assign vld_o  = out_vld_q;
  assign cost_o = cost_q;
  assign zden_o = zden_q;

endmodule

### rtl/core/zncc_matching_cost.sv
// ZNCC matching cost: top level with config register and output skid.
//
// Takes one word of window sums per cycle (Si, Sii, Sj, Sjj, Sij) and returns
// one word per cycle holding the Q1.15 zero-mean normalised cross-correlation
// cost (N*Sij - Si*Sj) / floor(sqrt(|var_i*var_j|)), truncated toward zero and
// saturated, with a zero-root flag in tuser (cost then reads 0).
// Throughput is one word per clock while the skid register is empty. The
// pipeline is the moments stages, then the square root, which resolves one
// root bit per stage for P = max(SQUARE_SUM_BITS + 9, 2*SUM_BITS) bits, then
// a fifteen-stage restoring divider, then the output register.
// The pipeline advances whenever the skid register is empty, so a new word is
// taken while a finished result waits on the output. Back-pressure stalls the
// whole pipeline only once the skid register has filled.
// window_pixels (N) is written through cfg_we_i/cfg_wdata_i, resets to 81 and
// must be changed only while the pipeline is empty.
module zncc_matching_cost #(
  parameter int unsigned SUM_BITS        = zncc_pkg::SUM_BITS_DEF,
  parameter int unsigned SQUARE_SUM_BITS = zncc_pkg::SQ_BITS_DEF,
  localparam int unsigned IN_W  = 2 * SUM_BITS + 3 * SQUARE_SUM_BITS,
  localparam int unsigned IN_WB = ((IN_W + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [zncc_pkg::N_BITS-1:0]      cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // refer_sum, refer_square_sum, target_sum, target_square_sum, cross_sum
  input  logic [IN_WB-1:0]                 s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cost
  output logic [zncc_pkg::COST_BITS-1:0]   m_axis_tdata,
  // zero_denominator
  output logic [0:0]                       m_axis_tuser
);
  import zncc_pkg::*;

  localparam int unsigned PA = SQUARE_SUM_BITS + N_BITS;
  localparam int unsigned PB = 2 * SUM_BITS;
  localparam int unsigned P  = (PA > PB) ? PA : PB;

  // field offsets within the input word
  localparam int unsigned OFS_SII = SUM_BITS;
  localparam int unsigned OFS_SJ  = OFS_SII + SQUARE_SUM_BITS;
  localparam int unsigned OFS_SJJ = OFS_SJ + SUM_BITS;
  localparam int unsigned OFS_SIJ = OFS_SJJ + SQUARE_SUM_BITS;

  logic [N_BITS-1:0] n_q;
  logic              en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= N_RESET;
    end else if (cfg_we_i) begin
      n_q <= cfg_wdata_i;
    end
  end

  // pipeline moves whenever the skid slot is free
  logic skid_vld_q;
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  logic                 mom_vld;
  logic signed [P:0]    mom_num;
  logic [2*P-1:0]       mom_rad;

  zncc_moments #(
    .SumBits (SUM_BITS),
    .SqBits  (SQUARE_SUM_BITS)
  ) u_moments (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .n_i    (n_q),
    .si_i   (s_axis_tdata[0 +: SUM_BITS]),
    .sii_i  (s_axis_tdata[OFS_SII +: SQUARE_SUM_BITS]),
    .sj_i   (s_axis_tdata[OFS_SJ +: SUM_BITS]),
    .sjj_i  (s_axis_tdata[OFS_SJJ +: SQUARE_SUM_BITS]),
    .sij_i  (s_axis_tdata[OFS_SIJ +: SQUARE_SUM_BITS]),
    .vld_o  (mom_vld),
    .num_o  (mom_num),
    .rad_o  (mom_rad)
  );

  logic              sq_vld;
  logic signed [P:0] sq_num;
  logic [P-1:0]      sq_root;

  zncc_sqrt #(
    .P (P)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (mom_vld),
    .num_i  (mom_num),
    .rad_i  (mom_rad),
    .vld_o  (sq_vld),
    .num_o  (sq_num),
    .root_o (sq_root)
  );

  logic                 dv_vld;
  logic [COST_BITS-1:0] dv_cost;
  logic                 dv_zden;

  zncc_div #(
    .P (P)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .num_i  (sq_num),
    .root_i (sq_root),
    .vld_o  (dv_vld),
    .cost_o (dv_cost),
    .zden_o (dv_zden)
  );

  // output register plus one skid slot
  logic                 out_vld_q;
  logic [COST_BITS-1:0] out_cost_q, skid_cost_q;
  logic                 out_zden_q, skid_zden_q;
  logic                 load;

  assign load = en && dv_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !m_axis_tready) begin
      if (load) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !m_axis_tready) begin
      if (load) begin
        skid_cost_q <= dv_cost;
        skid_zden_q <= dv_zden;
      end
    end else if (skid_vld_q) begin
      out_cost_q <= skid_cost_q;
      out_zden_q <= skid_zden_q;
    end else begin
      out_cost_q <= dv_cost;
      out_zden_q <= dv_zden;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_cost_q;
  assign m_axis_tuser  = out_zden_q;

endmodule

### rtl/core/zncc_checker.sv
// Port-level checks for the ZNCC matching cost block, bound to the top level.
module zncc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [zncc_pkg::COST_BITS-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);
  import zncc_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed under stall");

  // zero root always reads as zero cost
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("zero root with non-zero cost");

  // input side only blocks while a word waits on the output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with empty output");

  // skid slot drains as soon as the output is taken
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("input still blocked after output taken");

endmodule

bind zncc_matching_cost zncc_checker u_zncc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### sim/zncc_matching_cost_chk.sv
// Checker for the ZNCC matching cost block: predicts each cost and compares.
module zncc_matching_cost_chk #(
  parameter int unsigned SUM_BITS        = 17,
  parameter int unsigned SQUARE_SUM_BITS = 25,
  parameter int unsigned IN_WB           = 112
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [zncc_pkg::N_BITS-1:0]    cfg_wdata_i,
  input  logic                           s_valid_i,
  input  logic                           s_ready_i,
  input  logic [IN_WB-1:0]               s_data_i,
  input  logic                           m_valid_i,
  input  logic                           m_ready_i,
  input  logic [zncc_pkg::COST_BITS-1:0] m_data_i,
  input  logic [0:0]                     m_user_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] cost;
    logic        zero_den;
  } cost_t;

  logic [zncc_pkg::N_BITS-1:0] win_pixels;
  cost_t cost_q[$];

  function automatic logic [63:0] isqrt(logic [127:0] p);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 50; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= p) res = cand;
    end
    return res;
  endfunction

  function automatic cost_t zncc_cost(logic [IN_WB-1:0] w, logic [8:0] n_pix);
    longint n, si, sii, sj, sjj, sij, num, vi, vj;
    logic [63:0] root, a, q, r;
    logic [127:0] prod;
    cost_t c;
    int lo;
    lo = 0;
    si  = longint'(w[lo +: SUM_BITS]);        lo += SUM_BITS;
    sii = longint'(w[lo +: SQUARE_SUM_BITS]); lo += SQUARE_SUM_BITS;
    sj  = longint'(w[lo +: SUM_BITS]);        lo += SUM_BITS;
    sjj = longint'(w[lo +: SQUARE_SUM_BITS]); lo += SQUARE_SUM_BITS;
    sij = longint'(w[lo +: SQUARE_SUM_BITS]);
    n = longint'(n_pix);
    num = n * sij - si * sj;
    vi = n * sii - si * si;
    vj = n * sjj - sj * sj;
    if (vi < 0) vi = -vi;
    if (vj < 0) vj = -vj;
    prod = {64'd0, 64'(vi)} * {64'd0, 64'(vj)};
    root = isqrt(prod);
    if (root == 0) begin
      c.cost = '0;
      c.zero_den = 1'b1;
      return c;
    end
    a = (num < 0) ? 64'(-num) : 64'(num);
    if (a >= root) q = 64'd32768;
    else begin
      r = a;
      q = 0;
      for (int k = 0; k < 15; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= root) begin
          r -= root;
          q[0] = 1'b1;
        end
      end
    end
    if (num < 0) c.cost = 16'(-q);
    else c.cost = (q > 32767) ? 16'd32767 : q[15:0];
    c.zero_den = 1'b0;
    return c;
  endfunction

  assign pending_o = cost_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cost_t want;
    if (!rst_ni) begin
      win_pixels <= zncc_pkg::N_RESET;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) win_pixels <= cfg_wdata_i;
      if (s_valid_i && s_ready_i) cost_q.push_back(zncc_cost(s_data_i, win_pixels));
      if (m_valid_i && m_ready_i) begin
        if (cost_q.size() == 0) begin
          $display("%0t: unexpected word cost=%0d flag=%0d", $time,
                   $signed(m_data_i), m_user_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = cost_q.pop_front();
          if (want.cost !== m_data_i || want.zero_den !== m_user_i[0]) begin
            $display("%0t: mismatch exp cost=%0d flag=%0d got cost=%0d flag=%0d", $time,
                     $signed(want.cost), want.zero_den, $signed(m_data_i), m_user_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

### sim/zncc_matching_cost_tb.sv
// Testbench top for the ZNCC matching cost block: stimulus and verdict.
module zncc_matching_cost_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SB    = zncc_pkg::SUM_BITS_DEF;
  localparam int unsigned QB    = zncc_pkg::SQ_BITS_DEF;
  localparam int unsigned IN_W  = 2 * SB + 3 * QB;
  localparam int unsigned IN_WB = ((IN_W + 7) / 8) * 8;
  localparam int unsigned LAT   = 60;   // extra wait once no word is pending
  localparam int          WDOG  = 2000; // cycles with no word moved

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [zncc_pkg::N_BITS-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_WB-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [zncc_pkg::COST_BITS-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  int fail_count, pending;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  always #6 clk_i = ~clk_i;

  zncc_matching_cost dut (.*);

  zncc_matching_cost_chk #(.SUM_BITS(SB), .SQUARE_SUM_BITS(QB), .IN_WB(IN_WB)) chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_user_i(m_axis_tuser), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Pack one word, Si in the lowest bits.
  function automatic logic [IN_WB-1:0] pack_sums(logic [SB-1:0] si, logic [QB-1:0] sii,
                                                 logic [SB-1:0] sj, logic [QB-1:0] sjj,
                                                 logic [QB-1:0] sij);
    return IN_WB'({sij, sjj, sj, sii, si});
  endfunction

  // Sums from a plausible window of n pixels: consistent, so var >= 0 and |rho| <= 1.
  function automatic logic [IN_WB-1:0] window_sums(int n);
    longint si, sii, sj, sjj, sij, p, t;
    int mode;
    si = 0; sii = 0; sj = 0; sjj = 0; sij = 0;
    mode = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 255);
      case (mode)
        0: t = p;
        1: t = 255 - p;
        2: t = $urandom_range(0, 255);
        default: t = (p + $urandom_range(0, 20) > 255) ? 255 : p + $urandom_range(0, 20);
      endcase
      si += p; sii += p * p; sj += t; sjj += t * t; sij += p * t;
    end
    return pack_sums(SB'(si), QB'(sii), SB'(sj), QB'(sjj), QB'(sij));
  endfunction

  function automatic logic [IN_WB-1:0] noise_sums();
    return pack_sums(SB'($urandom), QB'($urandom), SB'($urandom), QB'($urandom),
                     QB'($urandom));
  endfunction

  // Valid stays high into the next word when there is no gap.
  task automatic send_word(logic [IN_WB-1:0] w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Wait for the pipe to empty before a register write.
  task automatic write_window(logic [8:0] n);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(logic [8:0] n, int count);
    int wn;
    write_window(n);
    for (int i = 0; i < count; i++) begin
      wn = (n == 0) ? $urandom_range(1, 289) : n;
      if ($urandom_range(0, 9) < 8) send_word(window_sums(wn));
      else send_word(noise_sums());
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Watchdog on words moved on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG && !stim_done) begin
      $display("** zncc_matching_cost: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [SB-1:0] smax;
    logic [QB-1:0] qmax;
    smax = '1;
    qmax = '1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed at reset window: zero root, saturation, extremes
    send_word(pack_sums('0, '0, '0, '0, '0));
    send_word(pack_sums(smax, qmax, smax, qmax, qmax));
    send_word(pack_sums('0, qmax, '0, qmax, qmax));      // positive saturation
    send_word(pack_sums(smax, '0, smax, '0, '0));        // negative num, odd vars
    send_word(pack_sums(SB'(81 * 10), QB'(81 * 100), SB'(81 * 5), QB'(81 * 25),
                        QB'(81 * 50)));                  // flat windows
    send_word(pack_sums(SB'(100), QB'(5000), SB'(200), QB'(9000), '0));
    send_word(pack_sums(SB'(4000), QB'(300000), SB'(5000), QB'(400000), QB'(200000)));
    send_word(pack_sums(SB'(20655), QB'(5267025), SB'(0), QB'(0), QB'(0)));
    for (int i = 0; i < 6; i++) send_word(window_sums(81));
    // window of zero pixels and the widest window
    write_window(9'd0);
    send_word(pack_sums(SB'(1000), QB'(20000), SB'(300), QB'(9000), QB'(7000)));
    send_word(pack_sums(smax, qmax, smax, qmax, qmax));
    write_window(9'd511);
    send_word(pack_sums(smax, qmax, smax, qmax, qmax));
    send_word(noise_sums());
    write_window(9'd289);
    send_word(window_sums(289));
    // long receiver hold-off while words keep arriving
    write_window(9'd9);
    hold_off = 1'b1;
    for (int i = 0; i < 120; i++) send_word(window_sums(9));
    random_phase(9'd81, 400);
    random_phase(9'd1, 150);
    random_phase(9'd25, 300);
    random_phase(9'd289, 150);
    random_phase(9'd0, 100);
    random_phase(9'($urandom_range(2, 511)), 330);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && idle_cycles < WDOG) @(posedge clk_i);
    stim_done = 1'b1;
    repeat (LAT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** zncc_matching_cost: PASSED **");
    end else begin
      $display("** zncc_matching_cost: FAILED **");
    end
    $finish;
  end
endmodule
